/* hw/rtl/crlf_pkg.sv */
// crlf_pkg: shared constants and controller/datapath interface types for the
// CRLF line framer. No dependencies.
package crlf_pkg;

  // Line store geometry
  localparam int LINE_BYTES = 64;
  localparam int ADDR_W     = $clog2(LINE_BYTES);
  localparam int CNT_W      = $clog2(LINE_BYTES + 1);

  // Character codes
  localparam logic [7:0] NL_CODE = 8'd10;
  localparam logic [7:0] CR_CODE = 8'd13;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr_en;       // append input byte to store
    logic clr;         // newline: clear count and drop mode
    logic drop;        // overflow: clear count, enter drop mode
    logic start_line;  // latch line length, rewind read index
    logic rd_en;       // read store at read index
    logic load_byte;   // load output register with read data
    logic load_empty;  // load output register with empty-line result
  } crlf_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_nl;       // input byte is a newline
    logic discarding;  // drop mode active
    logic full;        // store holds LINE_BYTES bytes
    logic line_empty;  // line is empty after CR strip
    logic rd_last;     // registered read data is the final byte
    logic out_free;    // output register can take a new result
  } crlf_stat_t;

endpackage

/* hw/rtl/crlf_dpath.sv */
// crlf_dpath: line store memory, fill count, drop flag, read sequencing and
// the output register. Depends on crlf_pkg.
module crlf_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_data_byte,
  input  crlf_pkg::crlf_cmd_t  cmd,
  output crlf_pkg::crlf_stat_t stat,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [7:0]           out_line_byte,
  output logic                 out_byte_valid,
  output logic                 out_last
);

  logic [7:0]                    mem [crlf_pkg::LINE_BYTES];
  logic [crlf_pkg::CNT_W-1:0]    fill_r, fill_nxt;
  logic                          disc_r, disc_nxt;
  logic                          last_cr_r;
  logic [crlf_pkg::CNT_W-1:0]    len_r;
  logic [crlf_pkg::ADDR_W-1:0]   rd_idx_r;
  logic [7:0]                    rdata_r;
  logic                          rlast_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_byte_r;
  logic                          out_bv_r;
  logic                          out_last_r;
  logic [crlf_pkg::CNT_W-1:0]    rd_next;

  // Status decode
  assign stat.is_nl      = (in_data_byte == crlf_pkg::NL_CODE);
  assign stat.discarding = disc_r;
  assign stat.full       = (fill_r == crlf_pkg::CNT_W'(crlf_pkg::LINE_BYTES));
  assign stat.line_empty = (fill_r == '0) ||
                           ((fill_r == crlf_pkg::CNT_W'(1)) && last_cr_r);
  assign stat.rd_last    = rlast_r;
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign rd_next = crlf_pkg::CNT_W'(rd_idx_r) + crlf_pkg::CNT_W'(1);

  // Fill count and drop mode
  always_comb begin
    fill_nxt = fill_r;
    disc_nxt = disc_r;
    if (cmd.clr) begin
      fill_nxt = '0;
      disc_nxt = 1'b0;
    end else if (cmd.drop) begin
      fill_nxt = '0;
      disc_nxt = 1'b1;
    end else if (cmd.wr_en) begin
      fill_nxt = fill_r + crlf_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      disc_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      disc_r <= disc_nxt;
    end
  end

  // Line store write; track whether the newest byte is a CR
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[fill_r[crlf_pkg::ADDR_W-1:0]] <= in_data_byte;
      last_cr_r <= (in_data_byte == crlf_pkg::CR_CODE);
    end
  end

  // Readout: latch length (trailing CR removed), then read one byte per request
  always_ff @(posedge clk) begin
    if (cmd.start_line) begin
      len_r    <= fill_r - crlf_pkg::CNT_W'(last_cr_r);
      rd_idx_r <= '0;
    end else if (cmd.rd_en) begin
      rdata_r  <= mem[rd_idx_r];
      rlast_r  <= (rd_next == len_r);
      rd_idx_r <= rd_next[crlf_pkg::ADDR_W-1:0];
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_byte || cmd.load_empty) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      out_byte_r <= rdata_r;
      out_bv_r   <= 1'b1;
      out_last_r <= rlast_r;
    end else if (cmd.load_empty) begin
      out_byte_r <= '0;
      out_bv_r   <= 1'b0;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_byte  = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_last       = out_last_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= crlf_pkg::CNT_W'(crlf_pkg::LINE_BYTES))
    else $error("fill count above store size");

  a_wr_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (!disc_r && !stat.full))
    else $error("append while dropping or full");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_byte || cmd.load_empty) |-> stat.out_free)
    else $error("output register overwritten while stalled");

endmodule

/* hw/rtl/crlf_ctrl.sv */
// crlf_ctrl: controller state machine for the CRLF line framer; decides per
// input byte and sequences line readout. Depends on crlf_pkg.
module crlf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  crlf_pkg::crlf_stat_t stat,
  output crlf_pkg::crlf_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_EMPTY
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = !rst_n || (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (stat.is_nl) begin
            cmd.clr = 1'b1;
            if (!stat.discarding) begin
              if (stat.line_empty) begin
                state_nxt = S_EMPTY;
              end else begin
                cmd.start_line = 1'b1;
                state_nxt      = S_READ;
              end
            end
          end else if (!stat.discarding) begin
            if (stat.full) begin
              cmd.drop = 1'b1;
            end else begin
              cmd.wr_en = 1'b1;
            end
          end
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.load_byte = 1'b1;
          state_nxt     = stat.rd_last ? S_IDLE : S_READ;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.load_empty = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/crlf_line_framer.sv */
// An ordinary byte is stored or, on overflow, dropped. A newline
// emits its line byte by byte: registered store read (S_READ), then output
// load (S_LOAD), held while the output register is not free; an empty line
// loads one empty result (S_EMPTY). Input is stalled until the line is out.
// Reset (rst_n low, synchronous) clears fill count, drop mode, controller
// state and output valid; the line store itself is not cleared.
module crlf_line_framer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_line_byte,
  output logic       out_byte_valid,
  output logic       out_last
);

  crlf_pkg::crlf_cmd_t  cmd;
  crlf_pkg::crlf_stat_t stat;

  // Controller
  crlf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath
  crlf_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_data_byte   (in_data_byte),
    .cmd            (cmd),
    .stat           (stat),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_line_byte  (out_line_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last)
  );

endmodule

/* test/tb_crlf_line_framer.sv */
// tb_crlf_line_framer: self-checking testbench for the CRLF line framer.
// Depends on crlf_pkg and crlf_line_framer; predicts every emitted line byte
// from its own model of the line store and compares each output transfer.
module tb_crlf_line_framer;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       byte_valid;
    logic       last;
  } line_result_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_line_byte;
  logic       out_byte_valid;
  logic       out_last;

  // Line model: store, fill count, dropping flag
  logic [7:0]                 line_mem [crlf_pkg::LINE_BYTES];
  logic [crlf_pkg::CNT_W-1:0] line_fill;
  logic                       dropping;

  line_result_t pending_line_bytes[$];
  int           errors;
  int           framed_bytes;
  bit           in_gaps_on;
  bit           out_gaps_on;
  int           hold_cycles;

  crlf_line_framer u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line_byte  (out_line_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Update the line model with one accepted byte; queue any line it completes
  task automatic frame_rx_byte(input logic [7:0] b);
    int           n;
    line_result_t r;
    if (b == crlf_pkg::NL_CODE) begin
      if (!dropping) begin
        n = int'(line_fill);
        if (n > 0 && line_mem[n-1] == crlf_pkg::CR_CODE) n--;
        if (n == 0) begin
          r = '{line_byte: 8'h00, byte_valid: 1'b0, last: 1'b1};
          pending_line_bytes.push_back(r);
        end else begin
          for (int k = 0; k < n; k++) begin
            r = '{line_byte: line_mem[k], byte_valid: 1'b1, last: (k == n - 1)};
            pending_line_bytes.push_back(r);
          end
        end
      end
      line_fill = '0;
      dropping  = 1'b0;
    end else if (!dropping) begin
      if (line_fill >= crlf_pkg::LINE_BYTES) begin
        line_fill = '0;
        dropping  = 1'b1;
      end else begin
        line_mem[line_fill] = b;
        line_fill++;
      end
    end
  endtask

  // Offer one byte from a falling edge, wait for its transfer, back on a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_rx_byte(b);
    framed_bytes++;
    @(negedge clk);
  endtask

  // Random line content: never a newline, carriage returns now and then
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    if ($urandom_range(0, 15) == 0) return crlf_pkg::CR_CODE;
    do b = 8'($urandom_range(0, 255)); while (b == crlf_pkg::NL_CODE);
    return b;
  endfunction

  task automatic send_line(input int len, input bit end_cr);
    repeat (len) send_byte(text_byte());
    if (end_cr) send_byte(crlf_pkg::CR_CODE);
    send_byte(crlf_pkg::NL_CODE);
  endtask

  // Sender pauses until every queued line byte has come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    wait (pending_line_bytes.size() == 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic test_empty_lines();
    send_byte(crlf_pkg::NL_CODE);
    send_byte(crlf_pkg::CR_CODE);
    send_byte(crlf_pkg::NL_CODE);
    send_byte(crlf_pkg::NL_CODE);
    wait_drain();
  endtask

  task automatic test_carriage_return();
    // only one trailing CR is stripped
    send_byte(8'h41);
    send_byte(crlf_pkg::CR_CODE);
    send_byte(crlf_pkg::CR_CODE);
    send_byte(crlf_pkg::NL_CODE);
    // CRs inside the line are kept
    send_byte(crlf_pkg::CR_CODE);
    send_byte(8'h42);
    send_byte(crlf_pkg::CR_CODE);
    send_byte(8'h43);
    send_byte(crlf_pkg::NL_CODE);
    wait_drain();
  endtask

  task automatic test_byte_extremes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(crlf_pkg::NL_CODE);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(crlf_pkg::NL_CODE);
    wait_drain();
  endtask

  task automatic test_store_full();
    // full store ending in two CRs keeps one of them
    repeat (crlf_pkg::LINE_BYTES - 2) send_byte(text_byte());
    send_byte(crlf_pkg::CR_CODE);
    send_line(0, 1'b1);
    wait_drain();
  endtask

  task automatic test_overflow_drop();
    // a CR past full triggers the drop; later text is lost up to the newline
    repeat (crlf_pkg::LINE_BYTES) send_byte(text_byte());
    send_byte(crlf_pkg::CR_CODE);
    repeat (3) send_byte(text_byte());
    send_byte(crlf_pkg::CR_CODE);
    send_byte(crlf_pkg::NL_CODE);
    send_line(1, 1'b0);
    // newline right after the drop
    send_line(crlf_pkg::LINE_BYTES + 1, 1'b0);
    send_line(3, 1'b1);
    wait_drain();
  endtask

  task automatic test_output_hold();
    hold_cycles = 300;
    repeat (2) send_line(10, 1'b0);
    send_line(0, 1'b0);
    wait_drain();
  endtask

  // Mostly well-formed lines of random length; some overflow, some noise
  task automatic test_random_traffic(input int count);
    int goal;
    int sel;
    goal = framed_bytes + count;
    while (framed_bytes < goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) send_line($urandom_range(0, 8), $urandom_range(0, 3) == 0);
      else if (sel < 75) send_line($urandom_range(9, 62), $urandom_range(0, 3) == 0);
      else if (sel < 85) send_line($urandom_range(63, 64), $urandom_range(0, 3) == 0);
      else if (sel < 92) send_line($urandom_range(65, 72), $urandom_range(0, 1) == 0);
      else repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end
    wait_drain();
  endtask

  // Receiver: random stall bursts, plus a long hold when a test asks for one
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        while (hold_cycles > 0) begin
          @(negedge clk);
          hold_cycles--;
        end
        out_stall <= 1'b0;
      end else if (out_gaps_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Compare each output transfer with the oldest predicted line byte
  always @(posedge clk) begin
    line_result_t want;
    if (rst_n === 1'b1 && $isunknown(out_valid)) begin
      errors++;
      $display("%0t: out_valid expected 0 or 1, got %b", $time, out_valid);
    end else if (rst_n === 1'b1 && out_valid && !out_stall) begin
      if (pending_line_bytes.size() == 0) begin
        errors++;
        $display("%0t: result expected none, got byte %0h valid %b last %b",
                 $time, out_line_byte, out_byte_valid, out_last);
      end else begin
        want = pending_line_bytes.pop_front();
        check_field("line_byte", want.line_byte, out_line_byte);
        check_field("byte_valid", 8'(want.byte_valid), 8'(out_byte_valid));
        check_field("last", 8'(want.last), 8'(out_last));
      end
    end
  end

  initial begin
    #40ms;
    $display("[crlf_line_framer] ERROR");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    errors       = 0;
    framed_bytes = 0;
    hold_cycles  = 0;
    in_gaps_on   = 1'b0;
    out_gaps_on  = 1'b0;
    line_fill    = '0;
    dropping     = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_lines();
    test_carriage_return();
    test_byte_extremes();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    test_store_full();
    test_overflow_drop();
    in_gaps_on = 1'b0;
    test_output_hold();
    in_gaps_on = 1'b1;
    test_random_traffic(80);
    // closing stretch at full rate on both sides
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    test_random_traffic(20);

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[crlf_line_framer] OK");
    end else begin
      $display("[crlf_line_framer] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/crlf_pkg.sv
hw/rtl/crlf_dpath.sv
hw/rtl/crlf_ctrl.sv
hw/rtl/crlf_line_framer.sv
test/tb_crlf_line_framer.sv
